>>> hw/rtl/tpsec_pkg.sv
// ----------------------------------------------------------------------------
// tpsec_pkg
// Shared widths, register indexes and types of the triangle / plane section
// unit.
// ----------------------------------------------------------------------------
package tpsec_pkg;

  // field widths
  localparam int COORD_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int NORM_W     = FRAC_W + 2;
  localparam int TOL_W      = 31;
  localparam int TAG_W      = 24;

  // datapath widths
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = DIFF_W + NORM_W;
  localparam int DIST_W     = PROD_W + 2;
  localparam int T_W        = 32;
  localparam int DIV_STAGES = T_W;
  localparam int SQ_W       = 2 * TOL_W;
  localparam int SUM_W      = SQ_W + 2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORG_X  = 3'd0,
    REG_ORG_Y  = 3'd1,
    REG_ORG_Z  = 3'd2,
    REG_NORM_X = 3'd3,
    REG_NORM_Y = 3'd4,
    REG_NORM_Z = 3'd5,
    REG_TOL    = 3'd6
  } cfg_reg_t;

  // one point: x, y, z from bit 0 upward
  typedef logic [2:0][COORD_W-1:0] point_t;

  typedef struct packed {
    point_t [2:0]     vert;
    logic [TAG_W-1:0] tag;
  } tri_t;

  // vertex class and edge crossing flags
  typedef struct packed {
    logic [2:0] on;
    logic [2:0] xing;
  } cls_t;

  // far end of edge e (edges 0-1, 1-2, 2-0)
  function automatic int edge_end(input int e);
    return (e == 2) ? 0 : e + 1;
  endfunction

  // the two candidates of pair p (0-1, 0-2, 1-2)
  function automatic int pair_a(input int p);
    return (p == 2) ? 1 : 0;
  endfunction

  function automatic int pair_b(input int p);
    return (p == 0) ? 1 : 2;
  endfunction

endpackage

>>> hw/rtl/triangle_plane_section_unit.sv
// ----------------------------------------------------------------------------
// triangle_plane_section_unit
// Slices one triangle per word against a configured plane and returns the
// section segment, its unique point count and the triangle tag.
// ----------------------------------------------------------------------------
// One triangle word is taken every clock while the pipeline advances. The
// crossing parameter t is formed by a restoring divider, one quotient bit per
// stage over 32 stages, between the distance stages and the interpolation and
// coincidence stages. The whole pipeline advances together: it holds while a
// finished result waits at the output and out_ready is low. Configuration
// should be written through cfg_we/cfg_index/cfg_wdata only while the unit is
// empty; the unit itself does not enforce this. Indexes beyond the tolerance
// register are ignored.
module triangle_plane_section_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [tpsec_pkg::COORD_W-1:0]  in_vert0_x,
  input  logic signed [tpsec_pkg::COORD_W-1:0]  in_vert0_y,
  input  logic signed [tpsec_pkg::COORD_W-1:0]  in_vert0_z,
  input  logic signed [tpsec_pkg::COORD_W-1:0]  in_vert1_x,
  input  logic signed [tpsec_pkg::COORD_W-1:0]  in_vert1_y,
  input  logic signed [tpsec_pkg::COORD_W-1:0]  in_vert1_z,
  input  logic signed [tpsec_pkg::COORD_W-1:0]  in_vert2_x,
  input  logic signed [tpsec_pkg::COORD_W-1:0]  in_vert2_y,
  input  logic signed [tpsec_pkg::COORD_W-1:0]  in_vert2_z,
  input  logic        [tpsec_pkg::TAG_W-1:0]    in_tri_tag,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_seg_valid,
  output logic        [1:0]                     out_point_count,
  output logic signed [tpsec_pkg::COORD_W-1:0]  out_seg_start_x,
  output logic signed [tpsec_pkg::COORD_W-1:0]  out_seg_start_y,
  output logic signed [tpsec_pkg::COORD_W-1:0]  out_seg_start_z,
  output logic signed [tpsec_pkg::COORD_W-1:0]  out_seg_end_x,
  output logic signed [tpsec_pkg::COORD_W-1:0]  out_seg_end_y,
  output logic signed [tpsec_pkg::COORD_W-1:0]  out_seg_end_z,
  output logic        [tpsec_pkg::TAG_W-1:0]    out_tag_out,
  input  logic                                  cfg_we,
  input  logic        [tpsec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [tpsec_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tpsec_pkg::*;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [COORD_W-1:0] org_r  [3];
  logic signed [NORM_W-1:0]  norm_r [3];
  logic        [TOL_W-1:0]   tol_r;
  logic        [SQ_W-1:0]    tol_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0]  <= '0;
      org_r[1]  <= '0;
      org_r[2]  <= '0;
      norm_r[0] <= '0;
      norm_r[1] <= '0;
      norm_r[2] <= NORM_W'(1) <<< FRAC_W;
      tol_r     <= TOL_W'(66);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORG_X:  org_r[0]  <= cfg_wdata[COORD_W-1:0];
        REG_ORG_Y:  org_r[1]  <= cfg_wdata[COORD_W-1:0];
        REG_ORG_Z:  org_r[2]  <= cfg_wdata[COORD_W-1:0];
        REG_NORM_X: norm_r[0] <= cfg_wdata[NORM_W-1:0];
        REG_NORM_Y: norm_r[1] <= cfg_wdata[NORM_W-1:0];
        REG_NORM_Z: norm_r[2] <= cfg_wdata[NORM_W-1:0];
        REG_TOL:    tol_r     <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // squared tolerance follows the register in the next cycle
  always_ff @(posedge clk) begin
    tol_sq_r <= SQ_W'(tol_r) * SQ_W'(tol_r);
  end

  // --------------------------------------------------------------------------
  // pipeline control: every stage advances together
  // --------------------------------------------------------------------------
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // --------------------------------------------------------------------------
  // stage registers
  // --------------------------------------------------------------------------
  tri_t                      tri_in;
  logic                      s1_vld_r, s2_vld_r, s3_vld_r;
  tri_t                      s1_tri_r, s2_tri_r, s3_tri_r;
  logic signed [DIFF_W-1:0]  s1_dif_r [3][3];
  logic signed [PROD_W-1:0]  s2_prd_r [3][3];
  logic signed [DIST_W-1:0]  s3_dst_r [3];

  logic                      dv_vld_r [DIV_STAGES+1];
  tri_t                      dv_tri_r [DIV_STAGES+1];
  cls_t                      dv_cls_r [DIV_STAGES+1];
  logic        [DIST_W-1:0]  dv_rem_r [DIV_STAGES+1][3];
  logic        [DIST_W-1:0]  dv_den_r [DIV_STAGES+1][3];
  logic        [T_W-1:0]     dv_q_r   [DIV_STAGES+1][3];
  logic        [DIST_W-1:0]  dv_rem_nxt [DIV_STAGES+1][3];
  logic        [DIST_W-1:0]  dv_den_nxt [DIV_STAGES+1][3];
  logic        [T_W-1:0]     dv_q_nxt   [DIV_STAGES+1][3];
  logic        [DIST_W:0]    dv_sh      [DIV_STAGES+1][3];
  cls_t                      cls_nxt;

  logic                      m1_vld_r, m2_vld_r;
  tri_t                      m1_tri_r, m2_tri_r;
  cls_t                      m1_cls_r, m2_cls_r;
  logic        [2*T_W-1:0]   m1_prd_r [3][3];
  logic                      m1_hi_r  [3][3];
  logic                      m1_neg_r [3][3];
  logic        [T_W-1:0]     m1_t_r   [3];
  point_t                    m2_pt_r  [3];

  logic                      c_vld_r, q1_vld_r, q2_vld_r;
  point_t                    c_cand_r [3];
  point_t                    q1_cand_r [3];
  point_t                    q2_cand_r [3];
  logic        [1:0]         c_nc_r, q1_nc_r, q2_nc_r;
  logic        [TAG_W-1:0]   c_tag_r, q1_tag_r, q2_tag_r;
  point_t                    cand_nxt [3];
  logic        [2:0]         nc_cnt;
  logic        [TOL_W-1:0]   q1_ud_r  [3][3];
  logic        [2:0]         q1_far_r, q2_far_r;
  logic        [SQ_W-1:0]    q2_sq_r  [3][3];

  logic                      out_seg_valid_r;
  logic        [1:0]         out_count_r;
  point_t                    out_start_r, out_end_r;
  logic        [TAG_W-1:0]   out_tag_r;

  // --------------------------------------------------------------------------
  // valid bits travel with the words
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      for (int s = 0; s <= DIV_STAGES; s++) dv_vld_r[s] <= 1'b0;
      m1_vld_r    <= 1'b0;
      m2_vld_r    <= 1'b0;
      c_vld_r     <= 1'b0;
      q1_vld_r    <= 1'b0;
      q2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= in_valid;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      dv_vld_r[0] <= s3_vld_r;
      for (int s = 1; s <= DIV_STAGES; s++) dv_vld_r[s] <= dv_vld_r[s-1];
      m1_vld_r    <= dv_vld_r[DIV_STAGES];
      m2_vld_r    <= m1_vld_r;
      c_vld_r     <= m2_vld_r;
      q1_vld_r    <= c_vld_r;
      q2_vld_r    <= q1_vld_r;
      out_valid_r <= q2_vld_r;
    end
  end

  // --------------------------------------------------------------------------
  // stages 1 to 3: offsets from the origin, products, signed distances
  // --------------------------------------------------------------------------
  assign tri_in.vert[0] = {in_vert0_z, in_vert0_y, in_vert0_x};
  assign tri_in.vert[1] = {in_vert1_z, in_vert1_y, in_vert1_x};
  assign tri_in.vert[2] = {in_vert2_z, in_vert2_y, in_vert2_x};
  assign tri_in.tag     = in_tri_tag;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tri_r <= tri_in;
      s2_tri_r <= s1_tri_r;
      s3_tri_r <= s2_tri_r;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          s1_dif_r[i][k] <= $signed({tri_in.vert[i][k][COORD_W-1], tri_in.vert[i][k]})
                          - $signed({org_r[k][COORD_W-1], org_r[k]});
          s2_prd_r[i][k] <= s1_dif_r[i][k] * norm_r[k];
        end
        s3_dst_r[i] <= DIST_W'(s2_prd_r[i][0]) + DIST_W'(s2_prd_r[i][1])
                     + DIST_W'(s2_prd_r[i][2]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // classify vertices and set up the crossing divisions
  // --------------------------------------------------------------------------
  logic signed [DIST_W-1:0] tw;
  logic        [2:0]        above, below;
  logic        [DIST_W-1:0] dmag [3];

  assign tw = $signed({{(DIST_W-TOL_W-FRAC_W){1'b0}}, tol_r, {FRAC_W{1'b0}}});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      above[i] = s3_dst_r[i] > tw;
      below[i] = s3_dst_r[i] < -tw;
      dmag[i]  = s3_dst_r[i][DIST_W-1] ? DIST_W'(-s3_dst_r[i]) : DIST_W'(s3_dst_r[i]);
    end
    for (int e = 0; e < 3; e++) begin
      cls_nxt.on[e]   = !above[e] && !below[e];
      cls_nxt.xing[e] = (above[e] && below[edge_end(e)])
                     || (below[e] && above[edge_end(e)]);
    end
  end

  // restoring division, one quotient bit per stage: t = |d0| / (|d0| + |d1|)
  always_comb begin
    for (int e = 0; e < 3; e++) begin
      dv_rem_nxt[0][e] = dmag[e];
      dv_den_nxt[0][e] = dmag[e] + dmag[edge_end(e)];
      dv_q_nxt[0][e]   = '0;
      dv_sh[0][e]      = '0;
    end
    for (int s = 1; s <= DIV_STAGES; s++) begin
      for (int e = 0; e < 3; e++) begin
        dv_sh[s][e]      = {dv_rem_r[s-1][e], 1'b0};
        dv_den_nxt[s][e] = dv_den_r[s-1][e];
        if (dv_sh[s][e] >= {1'b0, dv_den_r[s-1][e]}) begin
          dv_rem_nxt[s][e] = DIST_W'(dv_sh[s][e] - {1'b0, dv_den_r[s-1][e]});
          dv_q_nxt[s][e]   = {dv_q_r[s-1][e][T_W-2:0], 1'b1};
        end else begin
          dv_rem_nxt[s][e] = dv_sh[s][e][DIST_W-1:0];
          dv_q_nxt[s][e]   = {dv_q_r[s-1][e][T_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_tri_r[0] <= s3_tri_r;
      dv_cls_r[0] <= cls_nxt;
      for (int s = 1; s <= DIV_STAGES; s++) begin
        dv_tri_r[s] <= dv_tri_r[s-1];
        dv_cls_r[s] <= dv_cls_r[s-1];
      end
      for (int s = 0; s <= DIV_STAGES; s++) begin
        for (int e = 0; e < 3; e++) begin
          dv_rem_r[s][e] <= dv_rem_nxt[s][e];
          dv_den_r[s][e] <= dv_den_nxt[s][e];
          dv_q_r[s][e]   <= dv_q_nxt[s][e];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // interpolate crossings: p0 +/- floor(|p1 - p0| * t)
  // --------------------------------------------------------------------------
  logic signed [DIFF_W-1:0] edge_dif [3][3];
  logic        [DIFF_W-1:0] edge_ud  [3][3];
  logic        [DIFF_W-1:0] edge_off [3][3];
  logic signed [DIFF_W:0]   edge_pt  [3][3];

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 3; k++) begin
        edge_dif[e][k] = $signed({dv_tri_r[DIV_STAGES].vert[edge_end(e)][k][COORD_W-1],
                                  dv_tri_r[DIV_STAGES].vert[edge_end(e)][k]})
                       - $signed({dv_tri_r[DIV_STAGES].vert[e][k][COORD_W-1],
                                  dv_tri_r[DIV_STAGES].vert[e][k]});
        edge_ud[e][k]  = edge_dif[e][k][DIFF_W-1] ? DIFF_W'(-edge_dif[e][k])
                                                  : DIFF_W'(edge_dif[e][k]);
        edge_off[e][k] = (m1_hi_r[e][k] ? DIFF_W'(m1_t_r[e]) : '0)
                       + DIFF_W'(m1_prd_r[e][k][2*T_W-1:T_W]);
        edge_pt[e][k]  = m1_neg_r[e][k]
          ? $signed({{2{m1_tri_r.vert[e][k][COORD_W-1]}}, m1_tri_r.vert[e][k]})
            - $signed({1'b0, edge_off[e][k]})
          : $signed({{2{m1_tri_r.vert[e][k][COORD_W-1]}}, m1_tri_r.vert[e][k]})
            + $signed({1'b0, edge_off[e][k]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_tri_r <= dv_tri_r[DIV_STAGES];
      m1_cls_r <= dv_cls_r[DIV_STAGES];
      m2_tri_r <= m1_tri_r;
      m2_cls_r <= m1_cls_r;
      for (int e = 0; e < 3; e++) begin
        m1_t_r[e] <= dv_q_r[DIV_STAGES][e];
        for (int k = 0; k < 3; k++) begin
          m1_prd_r[e][k] <= (2*T_W)'(edge_ud[e][k][T_W-1:0])
                          * (2*T_W)'(dv_q_r[DIV_STAGES][e]);
          m1_hi_r[e][k]  <= edge_ud[e][k][DIFF_W-1];
          m1_neg_r[e][k] <= edge_dif[e][k][DIFF_W-1];
          m2_pt_r[e][k]  <= edge_pt[e][k][COORD_W-1:0];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // gather candidates: on-plane vertices first, then edge crossings
  // --------------------------------------------------------------------------
  always_comb begin
    nc_cnt = '0;
    for (int i = 0; i < 3; i++) cand_nxt[i] = '0;
    for (int i = 0; i < 3; i++) begin
      if (m2_cls_r.on[i] && nc_cnt < 3'd3) begin
        cand_nxt[nc_cnt[1:0]] = m2_tri_r.vert[i];
        nc_cnt = nc_cnt + 3'd1;
      end
    end
    for (int e = 0; e < 3; e++) begin
      if (m2_cls_r.xing[e] && nc_cnt < 3'd3) begin
        cand_nxt[nc_cnt[1:0]] = m2_pt_r[e];
        nc_cnt = nc_cnt + 3'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // coincidence: per-axis gaps, squares, then squared distance test
  // --------------------------------------------------------------------------
  logic signed [DIFF_W-1:0] pr_dif [3][3];
  logic        [DIFF_W-1:0] pr_ud  [3][3];
  logic        [2:0]        pr_far;

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      pr_far[p] = 1'b0;
      for (int k = 0; k < 3; k++) begin
        pr_dif[p][k] = $signed({c_cand_r[pair_a(p)][k][COORD_W-1], c_cand_r[pair_a(p)][k]})
                     - $signed({c_cand_r[pair_b(p)][k][COORD_W-1], c_cand_r[pair_b(p)][k]});
        pr_ud[p][k]  = pr_dif[p][k][DIFF_W-1] ? DIFF_W'(-pr_dif[p][k])
                                              : DIFF_W'(pr_dif[p][k]);
        if (pr_ud[p][k] >= DIFF_W'(tol_r)) pr_far[p] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_cand_r  <= cand_nxt;
      c_nc_r    <= nc_cnt[1:0];
      c_tag_r   <= m2_tri_r.tag;
      q1_cand_r <= c_cand_r;
      q1_nc_r   <= c_nc_r;
      q1_tag_r  <= c_tag_r;
      q1_far_r  <= pr_far;
      q2_cand_r <= q1_cand_r;
      q2_nc_r   <= q1_nc_r;
      q2_tag_r  <= q1_tag_r;
      q2_far_r  <= q1_far_r;
      for (int p = 0; p < 3; p++) begin
        for (int k = 0; k < 3; k++) begin
          q1_ud_r[p][k] <= pr_ud[p][k][TOL_W-1:0];
          q2_sq_r[p][k] <= SQ_W'(q1_ud_r[p][k]) * SQ_W'(q1_ud_r[p][k]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // drop coincident candidates and form the result word
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] pr_sum [3];
  logic [2:0]       pr_co;
  logic             keep1, keep2;
  logic [1:0]       nu;

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      pr_sum[p] = SUM_W'(q2_sq_r[p][0]) + SUM_W'(q2_sq_r[p][1]) + SUM_W'(q2_sq_r[p][2]);
      pr_co[p]  = !q2_far_r[p] && (pr_sum[p] < SUM_W'(tol_sq_r));
    end
    keep1 = (q2_nc_r >= 2'd2) && !pr_co[0];
    keep2 = (q2_nc_r == 2'd3) && !pr_co[1] && !(keep1 && pr_co[2]);
    nu    = ((q2_nc_r != 2'd0) ? 2'd1 : 2'd0) + {1'b0, keep1} + {1'b0, keep2};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_seg_valid_r <= (nu == 2'd2);
      out_count_r     <= nu;
      out_start_r     <= q2_cand_r[0];
      out_end_r       <= keep1 ? q2_cand_r[1] : (keep2 ? q2_cand_r[2] : '0);
      out_tag_r       <= q2_tag_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_seg_valid   = out_seg_valid_r;
  assign out_point_count = out_count_r;
  assign out_seg_start_x = out_start_r[0];
  assign out_seg_start_y = out_start_r[1];
  assign out_seg_start_z = out_start_r[2];
  assign out_seg_end_x   = out_end_r[0];
  assign out_seg_end_y   = out_end_r[1];
  assign out_seg_end_z   = out_end_r[2];
  assign out_tag_out     = out_tag_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_seg_count : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_seg_valid_r == (out_count_r == 2'd2)))
    else $error("segment flag disagrees with point count");

  a_end_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_count_r == 2'd0 || out_count_r == 2'd1)) |-> (out_end_r == '0))
    else $error("segment end set with fewer than two points");

  a_start_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_count_r == 2'd0) |-> (out_start_r == '0))
    else $error("segment start set with no points");

  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(q2_vld_r) && $stable(dv_vld_r[DIV_STAGES])))
    else $error("pipeline moved during a stall");

endmodule
